### hw/rtl/i2ctrf_pkg.sv
package i2ctrf_pkg;

    localparam int MAP_SIZE   = 256;
    localparam int PTR_W      = $clog2(MAP_SIZE);
    localparam int ADDR_W     = 7;
    localparam int DATA_W     = 8;
    localparam int OPCODE_W   = 2;

    localparam logic [ADDR_W-1:0] TARGET_ADDRESS_RESET = 7'h76;
    localparam logic [PTR_W-1:0]  SOFT_RESET_REG       = 8'hE0;
    localparam logic [DATA_W-1:0] SOFT_RESET_CMD       = 8'hB6;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CONNECT = 2'd0,
        OP_WRITE   = 2'd1,
        OP_READ    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic respond;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } ctrl_sts_t;

    // power-on contents of the register map
    function automatic logic [DATA_W-1:0] map_default(input logic [PTR_W-1:0] addr);
        logic [DATA_W-1:0] val;
        case (addr)
            8'hD0:   val = 8'h60;
            8'h88:   val = 8'h70;
            8'h89:   val = 8'h6B;
            8'h8A:   val = 8'h43;
            8'h8B:   val = 8'h67;
            8'h8C:   val = 8'h18;
            8'h8D:   val = 8'hFC;
            8'h8E:   val = 8'h7D;
            8'h8F:   val = 8'h8E;
            8'h90:   val = 8'h43;
            8'h91:   val = 8'hD6;
            8'h92:   val = 8'hD0;
            8'h93:   val = 8'h0B;
            8'h94:   val = 8'h27;
            8'h95:   val = 8'h0B;
            8'h96:   val = 8'h8C;
            8'h98:   val = 8'hF9;
            8'h99:   val = 8'hFF;
            8'h9A:   val = 8'h8C;
            8'h9B:   val = 8'h3C;
            8'h9C:   val = 8'hF8;
            8'h9D:   val = 8'hC6;
            8'h9E:   val = 8'h70;
            8'h9F:   val = 8'h17;
            8'hA1:   val = 8'h4B;
            8'hE1:   val = 8'h6A;
            8'hE2:   val = 8'h01;
            8'hE4:   val = 8'h14;
            8'hE5:   val = 8'h25;
            8'hE6:   val = 8'h03;
            8'hE7:   val = 8'h1E;
            8'hF7:   val = 8'h65;
            8'hF8:   val = 8'h5A;
            8'hF9:   val = 8'hC0;
            8'hFA:   val = 8'h7E;
            8'hFB:   val = 8'hED;
            8'hFD:   val = 8'h6F;
            8'hFE:   val = 8'h3B;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

### hw/rtl/i2ctrf_if.sv
interface i2ctrf_req_if;
    import i2ctrf_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [ADDR_W-1:0]   bus_address;
    logic                is_read;
    logic [DATA_W-1:0]   write_data;

    modport source (output valid, output opcode, output bus_address, output is_read,
                    output write_data, input ready);
    modport sink   (input valid, input opcode, input bus_address, input is_read,
                    input write_data, output ready);
endinterface

interface i2ctrf_rsp_if;
    import i2ctrf_pkg::*;

    logic              valid;
    logic              ready;
    logic              ack;
    logic [DATA_W-1:0] read_data;

    modport source (output valid, output ack, output read_data, input ready);
    modport sink   (input valid, input ack, input read_data, output ready);
endinterface

### hw/rtl/i2c_target_register_file.sv
// channel  dir  fields                                      handshake
// req      in   opcode, bus_address, is_read, write_data    valid/ready
// rsp      out  ack, read_data                              valid/ready
// cfg      in   cfg_wr_data (target address)                cfg_wr_en
//
// one word is processed at a time, in the steps capture, execute and respond;
// the result passes the item and read registers into the output register once that is free.
// the output register holds a finished word while the next one is accepted.
// a stalled rsp side holds the respond state; soft reset restores the map
// by clearing per-entry valid bits, no clearing pass after rst_n.
module i2c_target_register_file (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [i2ctrf_pkg::ADDR_W-1:0]   cfg_wr_data,
    i2ctrf_req_if.sink                      req,
    i2ctrf_rsp_if.source                    rsp
);
    import i2ctrf_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    i2ctrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    i2ctrf_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_opcode      (req.opcode),
        .in_bus_address (req.bus_address),
        .in_is_read     (req.is_read),
        .in_write_data  (req.write_data),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .out_ack        (rsp.ack),
        .out_read_data  (rsp.read_data)
    );

endmodule

### hw/rtl/i2ctrf_ctrl.sv
module i2ctrf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  i2ctrf_pkg::ctrl_sts_t sts,
    output i2ctrf_pkg::ctrl_cmd_t cmd
);
    import i2ctrf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                // hold until the output register can take the word
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.respond = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_RESP:
            begin
                cmd.respond = !sts.out_busy;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/i2ctrf_dpath.sv
module i2ctrf_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  i2ctrf_pkg::ctrl_cmd_t               cmd,
    output i2ctrf_pkg::ctrl_sts_t               sts,
    input  logic                                cfg_wr_en,
    input  logic [i2ctrf_pkg::ADDR_W-1:0]       cfg_wr_data,
    input  logic [i2ctrf_pkg::OPCODE_W-1:0]     in_opcode,
    input  logic [i2ctrf_pkg::ADDR_W-1:0]       in_bus_address,
    input  logic                                in_is_read,
    input  logic [i2ctrf_pkg::DATA_W-1:0]       in_write_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                out_ack,
    output logic [i2ctrf_pkg::DATA_W-1:0]       out_read_data
);
    import i2ctrf_pkg::*;

    logic [ADDR_W-1:0]   target_address_reg;

    logic [OPCODE_W-1:0] item_opcode_reg;
    logic [ADDR_W-1:0]   item_bus_address_reg;
    logic                item_is_read_reg;
    logic [DATA_W-1:0]   item_write_data_reg;

    logic [PTR_W-1:0]    pointer_reg;
    logic [PTR_W-1:0]    pointer_next;
    logic                addr_phase_reg;
    logic                addr_phase_next;

    logic [DATA_W-1:0]   map_mem [MAP_SIZE];
    logic [MAP_SIZE-1:0] map_valid_reg;
    logic                mem_we;
    logic                soft_reset;

    logic [DATA_W-1:0]   rd_data_reg;
    logic                rd_valid_reg;
    logic [DATA_W-1:0]   rd_default_reg;

    logic                out_valid_reg;
    logic                out_ack_reg;
    logic [DATA_W-1:0]   out_read_data_reg;
    logic                ack_next;
    logic [DATA_W-1:0]   read_data_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_address_reg <= TARGET_ADDRESS_RESET;
        end
        else if (cfg_wr_en)
        begin
            target_address_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_opcode_reg      <= in_opcode;
            item_bus_address_reg <= in_bus_address;
            item_is_read_reg     <= in_is_read;
            item_write_data_reg  <= in_write_data;
        end
    end

    // pointer, phase and map updates all happen in the exec cycle
    always_comb
    begin
        pointer_next    = pointer_reg;
        addr_phase_next = addr_phase_reg;
        mem_we          = 1'b0;
        soft_reset      = 1'b0;
        if (cmd.exec)
        begin
            case (item_opcode_reg)
                OP_CONNECT:
                begin
                    if (!item_is_read_reg)
                    begin
                        addr_phase_next = 1'b1;
                    end
                end
                OP_WRITE:
                begin
                    if (addr_phase_reg)
                    begin
                        pointer_next    = item_write_data_reg;
                        addr_phase_next = 1'b0;
                    end
                    else
                    begin
                        if (pointer_reg == SOFT_RESET_REG && item_write_data_reg == SOFT_RESET_CMD)
                        begin
                            soft_reset = 1'b1;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                        end
                        pointer_next = pointer_reg + 1'b1;
                    end
                end
                OP_READ:
                begin
                    pointer_next = pointer_reg + 1'b1;
                end
                default:
                begin
                    pointer_next = pointer_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pointer_reg    <= '0;
            addr_phase_reg <= 1'b1;
        end
        else
        begin
            pointer_reg    <= pointer_next;
            addr_phase_reg <= addr_phase_next;
        end
    end

    // an entry never written since the last restore reads as its default
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_valid_reg <= '0;
        end
        else if (soft_reset)
        begin
            map_valid_reg <= '0;
        end
        else if (mem_we)
        begin
            map_valid_reg[pointer_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[pointer_reg] <= item_write_data_reg;
        end
        if (cmd.exec)
        begin
            rd_data_reg    <= map_mem[pointer_reg];
            rd_valid_reg   <= map_valid_reg[pointer_reg];
            rd_default_reg <= map_default(pointer_reg);
        end
    end

    always_comb
    begin
        ack_next       = 1'b0;
        read_data_next = '0;
        case (item_opcode_reg)
            OP_CONNECT:
            begin
                ack_next = (item_bus_address_reg == target_address_reg);
            end
            OP_WRITE:
            begin
                ack_next = 1'b1;
            end
            OP_READ:
            begin
                read_data_next = rd_valid_reg ? rd_data_reg : rd_default_reg;
            end
            default:
            begin
                ack_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.respond)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            out_ack_reg       <= ack_next;
            out_read_data_reg <= read_data_next;
        end
    end

    assign sts.out_busy  = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign out_ack       = out_ack_reg;
    assign out_read_data = out_read_data_reg;

endmodule
